FILE: src/lsh_pkg.sv
// Shared types and constants for the 3x3 Laplacian sharpening block.
// Used by every module under src but lsh_ram; has no dependencies of its own.
`timescale 1ns / 1ps
package lsh_pkg;

   localparam int PIX_W          = 8;
   localparam int POS_W          = 10;
   localparam int CFG_DATA_W     = 11;
   localparam int CFG_INDEX_W    = 2;
   localparam int MAX_RESULTS    = 3;
   localparam int CNT_W          = 2;
   localparam int REQ_TDATA_W    = 24;
   localparam int RSP_TDATA_W    = 48;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int FRAME_RESET    = 1024;

   localparam logic [CFG_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CFG_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      pixel_type        pix;
   } rsp_item_type;

   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] count;
   } rsp_load_type;

endpackage

FILE: src/lsh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lsh_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lsh_kernel.sv
// Per-channel Laplacian sharpening: 5*centre minus four neighbours, clamped.
// Depends on lsh_pkg for the pixel type.
`timescale 1ns / 1ps
module lsh_kernel (
   input  lsh_pkg::pixel_type centre,
   input  lsh_pkg::pixel_type up,
   input  lsh_pkg::pixel_type down,
   input  lsh_pkg::pixel_type left,
   input  lsh_pkg::pixel_type right,
   output lsh_pkg::pixel_type result
);
   import lsh_pkg::*;

   // The sum spans -1020..1275, so twelve signed bits hold it.
   function automatic logic [PIX_W-1:0] sharpen_chan(
      input logic [PIX_W-1:0] c,
      input logic [PIX_W-1:0] u,
      input logic [PIX_W-1:0] d,
      input logic [PIX_W-1:0] l,
      input logic [PIX_W-1:0] r
   );
      logic signed [11:0] acc;
      logic [PIX_W-1:0]   res;
      acc = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
            - $signed({4'b0000, u}) - $signed({4'b0000, d})
            - $signed({4'b0000, l}) - $signed({4'b0000, r});
      if (acc < 0) begin
         res = '0;
      end else if (acc > 12'sd255) begin
         res = '1;
      end else begin
         res = acc[PIX_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      result.red   = sharpen_chan(centre.red, up.red, down.red, left.red, right.red);
      result.green = sharpen_chan(centre.green, up.green, down.green, left.green,
                                  right.green);
      result.blue  = sharpen_chan(centre.blue, up.blue, down.blue, left.blue, right.blue);
   end

endmodule

FILE: src/lsh_rsp_buf.sv
// Result register: holds the up to three results of one pixel and sends them in order.
// Depends on lsh_pkg for the result item and load control types.
`timescale 1ns / 1ps
module lsh_rsp_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  lsh_pkg::rsp_load_type      load_ctl,
   input  lsh_pkg::rsp_item_type      slots [lsh_pkg::MAX_RESULTS],
   output logic                       free,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lsh_pkg::RSP_TDATA_W-1:0] rsp_tdata, // out_col, out_row, red, green, blue
   output logic                       rsp_tlast
);
   import lsh_pkg::*;

   rsp_item_type     slot_ff [MAX_RESULTS];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   rsp_item_type     cur;
   logic             is_last;
   logic             xfer;

   assign rsp_tvalid = (cnt_ff != '0);
   assign is_last    = ((idx_ff + 1'b1) == cnt_ff);
   assign xfer       = rsp_tvalid && rsp_tready;
   assign free       = !rsp_tvalid || (xfer && is_last);

   always_comb begin
      case (idx_ff)
         2'd0:    cur = slot_ff[0];
         2'd1:    cur = slot_ff[1];
         2'd2:    cur = slot_ff[2];
         default: cur = slot_ff[0];
      endcase
   end

   assign rsp_tdata = {4'b0000, cur.pix.blue, cur.pix.green, cur.pix.red, cur.row, cur.col};
   assign rsp_tlast = is_last;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load_ctl.load) begin
         cnt_in = load_ctl.count;
         idx_in = '0;
      end else if (xfer) begin
         if (is_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ctl.load) begin
         slot_ff <= slots;
      end
   end

endmodule

FILE: src/laplacian_sharpen_3x3_top.sv
// Top level of the 3x3 Laplacian sharpening block: input register, two-row line
// store, window registers, kernel and result register. Depends on lsh_pkg,
// lsh_ram, lsh_kernel and lsh_rsp_buf.
//
//   Channel  Direction  Payload                                  Last / kind
//   req_     in         tdata: red_in, green_in, blue_in         -
//   rsp_     out        tdata: out_col, out_row, red, green, blue tlast = run_last
//   csr_     in         csr_index, csr_data (frame width/height)  -
//
// A pixel moves from the input register through the kernel into the result
// register once the result register is free, so the block takes one pixel per
// cycle while each pixel causes at most one result and the receiver is ready.
// Pixels that end a row or fall in the last row can cause two or three
// results, which leave one after another through the single result port.
// Reset is synchronous; the line store is not cleared. Any register write
// restarts the frame at column and row zero.
`timescale 1ns / 1ps
module laplacian_sharpen_3x3_top #(
   parameter int MAX_WIDTH  = lsh_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lsh_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsh_pkg::REQ_TDATA_W-1:0]   req_tdata,  // red_in, green_in, blue_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsh_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // out_col, out_row, red, green,
                                                         // blue, zero pad
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsh_pkg::CFG_INDEX_W-1:0]   csr_index,
   input  logic [lsh_pkg::CFG_DATA_W-1:0]    csr_data
);
   import lsh_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int W_RESET = (FRAME_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_RESET;
   localparam int H_RESET = (FRAME_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_RESET;

   // Configuration.
   logic          csr_xfer;
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [31:0]   csr_val;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign csr_val   = 32'(csr_data);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_xfer) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (csr_val == 32'd0) begin
                  width_in = WW'(1);
               end else if (csr_val > 32'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = csr_val[WW-1:0];
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_val == 32'd0) begin
                  height_in = HW'(1);
               end else if (csr_val > 32'(MAX_HEIGHT)) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = csr_val[HW-1:0];
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // Input register.
   logic      in_valid_ff, in_valid_in;
   pixel_type in_pix_ff;
   logic      rsp_free;
   logic      process;
   logic      req_xfer;

   assign process    = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || process;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_pix_ff.red   <= req_tdata[7:0];
         in_pix_ff.green <= req_tdata[15:8];
         in_pix_ff.blue  <= req_tdata[23:16];
      end
   end

   // Position counters.
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic          row_end;
   logic          frame_end;

   assign row_end   = (32'(x_ff) + 32'd1 == 32'(width_ff));
   assign frame_end = (32'(y_ff) + 32'd1 == 32'(height_ff));

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (csr_xfer) begin
         x_in = '0;
         y_in = '0;
      end else if (process) begin
         if (row_end) begin
            x_in = '0;
            y_in = frame_end ? '0 : y_ff + 1'b1;
         end else begin
            x_in = x_ff + 1'b1;
         end
      end
   end

   // Line store: one bank per row parity, read ahead at the next column.
   logic            par;
   logic [1:0]      wr_en;
   pixel_type       ram_rd [2];
   logic [1:0]      byp_hit_ff;
   pixel_type       byp_data_ff;
   pixel_type [1:0] bank_rd;
   pixel_type       prev_row, prev2_row;

   assign par   = y_ff[0];
   assign wr_en = {process && par, process && !par};

   for (genvar b = 0; b < 2; b++) begin : g_bank
      lsh_ram #(
         .WIDTH(REQ_TDATA_W),
         .DEPTH(MAX_WIDTH)
      ) u_ram (
         .clock  (clock),
         .wr_en  (wr_en[b]),
         .wr_addr(x_ff),
         .wr_data(in_pix_ff),
         .rd_addr(x_in),
         .rd_data(ram_rd[b])
      );
   end

   // A write to the address being read forwards the new pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= '0;
      end else begin
         byp_hit_ff <= wr_en & {2{x_ff == x_in}};
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= in_pix_ff;
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         bank_rd[k] = byp_hit_ff[k] ? byp_data_ff : ram_rd[k];
      end
   end

   assign prev_row  = par ? bank_rd[0] : bank_rd[1];
   assign prev2_row = par ? bank_rd[1] : bank_rd[0];

   // Window registers.
   pixel_type uw_ff [3];
   pixel_type td_ff [2];
   pixel_type left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         uw_ff[0] <= '0;
         uw_ff[1] <= '0;
         uw_ff[2] <= '0;
         td_ff[0] <= '0;
         td_ff[1] <= '0;
         left_ff  <= '0;
      end else if (process) begin
         uw_ff[0] <= uw_ff[1];
         uw_ff[1] <= uw_ff[2];
         uw_ff[2] <= prev_row;
         td_ff[0] <= td_ff[1];
         td_ff[1] <= prev2_row;
         left_ff  <= in_pix_ff;
      end
   end

   // Kernel on the pixel one row and one column behind the input.
   pixel_type sharp;
   logic      interior;

   lsh_kernel u_kernel (
      .centre(uw_ff[2]),
      .up    (td_ff[1]),
      .down  (left_ff),
      .left  (uw_ff[1]),
      .right (prev_row),
      .result(sharp)
   );

   assign interior = (32'(x_ff) >= 32'd2) && (32'(y_ff) >= 32'd2) &&
                     (32'(x_ff) < 32'(width_ff)) && (32'(y_ff) < 32'(height_ff));

   // Candidate results in emission order, packed into the result slots.
   rsp_item_type cand [MAX_RESULTS];
   logic         cand_v [MAX_RESULTS];
   rsp_item_type slots_in [MAX_RESULTS];
   logic [CNT_W-1:0] n_res;
   rsp_load_type load_ctl;
   logic [31:0]  col0, row0, col1, col2, row2;

   always_comb begin
      col0 = 32'(x_ff) - 32'd1;
      row0 = 32'(y_ff) - 32'd1;
      col1 = 32'(width_ff) - 32'd1;
      col2 = 32'(x_ff);
      row2 = 32'(height_ff) - 32'd1;

      cand_v[0]   = (x_ff != '0) && (y_ff != '0);
      cand[0].col = col0[POS_W-1:0];
      cand[0].row = row0[POS_W-1:0];
      cand[0].pix = interior ? sharp : uw_ff[2];

      cand_v[1]   = row_end && (y_ff != '0);
      cand[1].col = col1[POS_W-1:0];
      cand[1].row = row0[POS_W-1:0];
      cand[1].pix = prev_row;

      cand_v[2]   = frame_end;
      cand[2].col = col2[POS_W-1:0];
      cand[2].row = row2[POS_W-1:0];
      cand[2].pix = in_pix_ff;
   end

   always_comb begin
      n_res = '0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         slots_in[k] = cand[k];
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (cand_v[k]) begin
            slots_in[n_res] = cand[k];
            n_res = n_res + 1'b1;
         end
      end
      load_ctl.load  = process;
      load_ctl.count = n_res;
   end

   lsh_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load_ctl  (load_ctl),
      .slots     (slots_in),
      .free      (rsp_free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WW'(W_RESET);
         height_ff   <= HW'(H_RESET);
         in_valid_ff <= 1'b0;
         x_ff        <= '0;
         y_ff        <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_valid_ff <= in_valid_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
      end
   end

endmodule

FILE: tb/laplacian_sharpen_checker.sv
// Scoreboard for the 3x3 Laplacian sharpening block: watches the pixel, result
// and register channels, predicts every result and compares it field by field.
// Depends on lsh_pkg for widths, register indexes and the pixel type.
`timescale 1ns / 1ps
module laplacian_sharpen_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lsh_pkg::REQ_TDATA_W-1:0] req_tdata,   // red_in, green_in, blue_in
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [lsh_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // out_col, out_row, red, green,
                                                        // blue, pad
   input  logic                            rsp_tlast,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [lsh_pkg::CFG_INDEX_W-1:0] csr_index,
   input  logic [lsh_pkg::CFG_DATA_W-1:0]  csr_data,
   output int                              pending_count,
   output int                              fail_count
);
   import lsh_pkg::*;

   localparam int STORE_W     = DEF_MAX_WIDTH;
   localparam int CENTRE_GAIN = 5;
   localparam int PIX_MAX     = 255;
   localparam int ROW_LSB     = POS_W;
   localparam int RED_LSB     = 2 * POS_W;
   localparam int GREEN_LSB   = RED_LSB + PIX_W;
   localparam int BLUE_LSB    = GREEN_LSB + PIX_W;

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      pixel_type        pix;
      logic             last;
   } out_pixel_type;

   out_pixel_type         expected_q[$];
   pixel_type             line_mem [0:2*STORE_W-1];
   pixel_type             upper_win [0:2];
   pixel_type             top_dly [0:1];
   pixel_type             left_pix;
   logic [CFG_DATA_W-1:0] width_reg;
   logic [CFG_DATA_W-1:0] height_reg;
   int unsigned           col_pos;
   int unsigned           row_pos;
   int                    errors = 0;

   function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [PIX_W-1:0] sharpen_chan(logic [PIX_W-1:0] c, u, d, l, r);
      int v;
      v = CENTRE_GAIN * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
      if (v < 0) v = 0;
      if (v > PIX_MAX) v = PIX_MAX;
      return v[PIX_W-1:0];
   endfunction

   function automatic pixel_type sharpen(pixel_type c, u, d, l, r);
      pixel_type s;
      s.red   = sharpen_chan(c.red, u.red, d.red, l.red, r.red);
      s.green = sharpen_chan(c.green, u.green, d.green, l.green, r.green);
      s.blue  = sharpen_chan(c.blue, u.blue, d.blue, l.blue, r.blue);
      return s;
   endfunction

   task automatic push_result(int unsigned col, int unsigned row, pixel_type pix);
      out_pixel_type item;
      item.col  = col[POS_W-1:0];
      item.row  = row[POS_W-1:0];
      item.pix  = pix;
      item.last = 1'b0;
      expected_q.push_back(item);
   endtask

   task automatic accept_pixel(input pixel_type pix);
      int unsigned w, h, x, y, xi, par, first;
      pixel_type   centre;
      w     = clamp_size(width_reg, DEF_MAX_WIDTH);
      h     = clamp_size(height_reg, DEF_MAX_HEIGHT);
      x     = col_pos;
      y     = row_pos;
      xi    = (x < STORE_W) ? x : STORE_W - 1;
      par   = y % 2;
      first = expected_q.size();

      // The window trails the input by one column; the older row passes through
      // its own two-stage delay to line up with the centre column.
      upper_win[0] = upper_win[1];
      upper_win[1] = upper_win[2];
      upper_win[2] = line_mem[(1 - par) * STORE_W + xi];
      top_dly[0]   = top_dly[1];
      top_dly[1]   = line_mem[par * STORE_W + xi];

      if (x >= 1 && y >= 1) begin
         centre = upper_win[1];
         if (x >= 2 && x + 1 <= w && y >= 2 && y + 1 <= h)
            centre = sharpen(centre, top_dly[0], left_pix, upper_win[0], upper_win[2]);
         push_result(x - 1, y - 1, centre);
      end
      if (x + 1 == w && y >= 1) push_result(w - 1, y - 1, upper_win[2]);
      if (y + 1 == h) push_result(x, h - 1, pix);
      if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;

      line_mem[par * STORE_W + xi] = pix;
      left_pix = pix;
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      col_pos = x;
      row_pos = y;
   endtask

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic check_result();
      out_pixel_type want;
      if (expected_q.size() == 0) begin
         $error("result for col %0d row %0d arrived with no result outstanding",
                rsp_tdata[0 +: POS_W], rsp_tdata[ROW_LSB +: POS_W]);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      compare_field("out_col", want.col, rsp_tdata[0 +: POS_W]);
      compare_field("out_row", want.row, rsp_tdata[ROW_LSB +: POS_W]);
      compare_field("red_out", want.pix.red, rsp_tdata[RED_LSB +: PIX_W]);
      compare_field("green_out", want.pix.green, rsp_tdata[GREEN_LSB +: PIX_W]);
      compare_field("blue_out", want.pix.blue, rsp_tdata[BLUE_LSB +: PIX_W]);
      compare_field("run_last", want.last, rsp_tlast);
   endtask

   always @(posedge clock) begin
      pixel_type in_pix;
      if (reset) begin
         width_reg  = CFG_DATA_W'(FRAME_RESET);
         height_reg = CFG_DATA_W'(FRAME_RESET);
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (upper_win[i]) upper_win[i] = '0;
         foreach (top_dly[i]) top_dly[i] = '0;
         left_pix = '0;
         col_pos  = 0;
         row_pos  = 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            // Any write, even to an unused index, restarts the frame.
            if (csr_index == CSR_FRAME_WIDTH) width_reg = csr_data;
            else if (csr_index == CSR_FRAME_HEIGHT) height_reg = csr_data;
            col_pos = 0;
            row_pos = 0;
         end
         if (req_tvalid && req_tready) begin
            in_pix.red   = req_tdata[0 +: PIX_W];
            in_pix.green = req_tdata[PIX_W +: PIX_W];
            in_pix.blue  = req_tdata[2*PIX_W +: PIX_W];
            accept_pixel(in_pix);
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
      pending_count <= expected_q.size();
      fail_count    <= errors;
   end

endmodule

FILE: tb/tb_laplacian_sharpen_3x3_top.sv
// Testbench top for laplacian_sharpen_3x3_top: drives frames of pixels and
// register writes with bursty traffic and a stalling receiver, and reports the
// verdict. Depends on lsh_pkg, the block under test and laplacian_sharpen_checker.
`timescale 1ns / 1ps
module tb_laplacian_sharpen_3x3_top;
   import lsh_pkg::*;

   localparam int RANDOM_PIXELS = 330;
   localparam int DIRECTED_RUN  = 24;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 4;

   localparam logic [CFG_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CFG_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   // A 4x3 frame, red in the top byte. The two interior pixels clamp high on
   // one channel and low on another.
   localparam logic [23:0] DEMO_FRAME [0:11] = '{
      24'h010203, 24'h000AFF, 24'hFFFF00, 24'h804020,
      24'h000AFF, 24'hFF2800, 24'h000AFF, 24'hFF0000,
      24'h070707, 24'h000AFF, 24'h000000, 24'hFFFFFF
   };

   typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_DARK, STYLE_BRIGHT} pix_style_type;
   typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CFG_INDEX_W-1:0] csr_index  = '0;
   logic [CFG_DATA_W-1:0]  csr_data   = '0;
   int                     pending_count;
   int                     fail_count;

   int          burst_left    = 0;
   bit          steady_sender = 1'b0;
   int          cycle_count   = 0;
   rx_mode_type rx_mode       = RX_OPEN;
   int          rx_span       = 0;
   int          rx_run        = 0;

   laplacian_sharpen_3x3_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   laplacian_sharpen_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver switches between always ready, random stalls and
   // alternating stretches of ready and stall.
   always @(posedge clock) begin
      if (rx_span == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_span = $urandom_range(40, 300);
      end
      rx_span--;
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (rx_run == 0) begin
               rx_run = $urandom_range(1, 8);
               rsp_tready <= !rsp_tready;
            end
            rx_run--;
         end
      endcase
   end

   function automatic logic [PIX_W-1:0] rand_channel(pix_style_type style);
      case (style)
         STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         STYLE_DARK:    return PIX_W'($urandom_range(0, 40));
         STYLE_BRIGHT:  return PIX_W'($urandom_range(200, 255));
         default:       return PIX_W'($urandom);
      endcase
   endfunction

   // Registers change only while no result is outstanding.
   task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_index <= index;
      csr_data  <= value[CFG_DATA_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input pixel_type pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_sender ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= {pix.blue, pix.green, pix.red};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int            w, h, wq, hq, frame_px, count, sent;
      pix_style_type style;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // One full small frame, then a partial one cut short by a write to an
      // unused register index.
      write_reg(CSR_FRAME_WIDTH, 4);
      write_reg(CSR_FRAME_HEIGHT, 3);
      for (int i = 0; i < 12; i++) send_pixel(pixel_type'(DEMO_FRAME[i]));
      for (int i = 0; i < 3; i++) send_pixel(pixel_type'(DEMO_FRAME[i + 4]));
      write_reg(CSR_SPARE_LO, 'h7FF);
      for (int i = 0; i < 3; i++) send_pixel(pixel_type'(DEMO_FRAME[i + 5]));
      write_reg(CSR_SPARE_HI, 0);

      // Zero sizes behave as one: every pixel is a whole frame.
      write_reg(CSR_FRAME_WIDTH, 0);
      write_reg(CSR_FRAME_HEIGHT, 0);
      send_pixel(pixel_type'(24'h000000));
      send_pixel(pixel_type'(24'hFFFFFF));
      send_pixel(pixel_type'(24'h5AA5C3));

      // Oversized width clamps to the widest row; the start of a two-row frame.
      write_reg(CSR_FRAME_WIDTH, 'h7FF);
      write_reg(CSR_FRAME_HEIGHT, 2);
      steady_sender = 1'b1;
      for (int i = 0; i < DIRECTED_RUN; i++)
         send_pixel('{rand_channel(STYLE_UNIFORM), rand_channel(STYLE_UNIFORM),
                      rand_channel(STYLE_UNIFORM)});

      // Tallest frame, one pixel wide; its first rows.
      w = 1;
      h = DEF_MAX_HEIGHT;
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      steady_sender = 1'b0;
      for (int i = 0; i < DIRECTED_RUN; i++)
         send_pixel('{rand_channel(STYLE_UNIFORM), rand_channel(STYLE_UNIFORM),
                      rand_channel(STYLE_UNIFORM)});

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         // Some phases keep the old setting so the frame carries on or wraps.
         if ($urandom_range(0, 3) != 0) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0) w = $urandom_range(1020, 2047);
            if ($urandom_range(0, 19) == 0) h = $urandom_range(1020, 2047);
            if ($urandom_range(0, 1) == 0) begin
               write_reg(CSR_FRAME_WIDTH, w);
               write_reg(CSR_FRAME_HEIGHT, h);
            end else begin
               write_reg(CSR_FRAME_HEIGHT, h);
               write_reg(CSR_FRAME_WIDTH, w);
            end
            if ($urandom_range(0, 7) == 0)
               write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
         end
         wq = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
         hq = (h == 0) ? 1 : ((h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h);
         frame_px = wq * hq;
         if (frame_px <= 120 && $urandom_range(0, 2) != 0)
            count = frame_px * $urandom_range(1, 2);
         else
            count = $urandom_range(1, 60);
         if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
         style = pix_style_type'($urandom_range(0, 3));
         steady_sender = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < count; i++)
            send_pixel('{rand_channel(style), rand_channel(style), rand_channel(style)});
         sent += count;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
